/* rtl/pfde_pkg.sv */
// Shared constants and operation codes of the page framebuffer draw engine.
package pfde_pkg;

	// Widths of the command fields.
	localparam int FUNC_W = 3;
	localparam int X_W    = 7;
	localparam int Y_W    = 6;
	localparam int LEN_W  = 7;

	// Default screen size.
	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// Page geometry: eight vertically stacked pixels per byte, bit 0 on top.
	localparam int PAGE_BITS  = 8;
	localparam int PAGE_SHIFT = $clog2(PAGE_BITS);
	localparam logic [PAGE_BITS-1:0]  PAGE_FULL = 8'hFF;
	localparam logic [PAGE_SHIFT-1:0] LAST_BIT  = 3'd7;

	// A line end row (start plus length) always fits in this many bits.
	localparam int YE_W = 8;
	localparam int PG_W = YE_W - PAGE_SHIFT;

	// Operation codes carried in the func field.
	localparam logic [FUNC_W-1:0] OP_SET   = 3'd0;
	localparam logic [FUNC_W-1:0] OP_GET   = 3'd1;
	localparam logic [FUNC_W-1:0] OP_HLINE = 3'd2;
	localparam logic [FUNC_W-1:0] OP_VLINE = 3'd3;
	localparam logic [FUNC_W-1:0] OP_FLUSH = 3'd4;

	typedef logic [PAGE_BITS-1:0] page_t;

endpackage

/* rtl/pfde_cmd_if.sv */
// Command channel of the page framebuffer draw engine.
interface pfde_cmd_if import pfde_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [X_W-1:0]    x;
	logic [Y_W-1:0]    y;
	logic [LEN_W-1:0]  length;
	logic              on;

	modport source (output valid, func, x, y, length, on, input ready);
	modport sink (input valid, func, x, y, length, on, output ready);
endinterface

/* rtl/pfde_res_if.sv */
// Result channel of the page framebuffer draw engine.
interface pfde_res_if ();
	logic valid;
	logic ready;
	logic pixel;
	logic update_needed;

	modport source (output valid, pixel, update_needed, input ready);
	modport sink (input valid, pixel, update_needed, output ready);
endinterface

/* rtl/pfde_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/page_framebuffer_draw_engine.sv */
// Top level of the page framebuffer draw engine.
//
// Commands arrive on the cmd channel (func, x, y, length, on) and every command
// gives exactly one result on the res channel (pixel, update_needed), in order.
// The screen lives in one page memory, one byte per column and page, which the
// engine reads, modifies and writes back one byte per cycle.
// A command is taken only while the engine is idle. Set pixel and get pixel
// read one byte, which set pixel writes back; a horizontal line walks its
// columns and a vertical line its pages, one byte each; flush, unused codes
// and off-screen commands touch no memory. The next command is taken in the
// cycle after the result is registered.
// The memory read port, one byte per cycle, sets the pace of a line.
// After reset the engine clears the page memory, one byte a cycle, all
// SCREEN_WIDTH * pages bytes (1024 at the default size), before it takes a command.
// The result sits in an output register: while the receiver stalls the engine
// still takes and works on one more command, and holds its result until the
// output register frees up.
module page_framebuffer_draw_engine import pfde_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pfde_cmd_if.sink     cmd,
	pfde_res_if.source   res
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_BITS - 1) / PAGE_BITS;
	localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int MAX_RUN     = (SCREEN_WIDTH > PAGE_COUNT) ? SCREEN_WIDTH : PAGE_COUNT;
	localparam int CNT_W       = $clog2(MAX_RUN);
	localparam int CW          = $clog2(SCREEN_WIDTH);
	localparam int CXW         = (CW > 8) ? CW : 8;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               first_q;
	logic               vline_q;
	logic               wr_q;
	logic               get_q;
	logic               on_q;
	logic [PAGE_SHIFT-1:0] bit_q;
	page_t              m_first_q;
	page_t              m_last_q;
	page_t              m_mid_q;
	logic               dirty_q;
	logic               res_dirty_q;
	logic               res_pix_q;
	logic               out_valid_q;
	logic               out_pixel_q;
	logic               out_dirty_q;

	logic               s1_valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	page_t              mask_s1;

	// Memory port signals.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	page_t              ram_wdata;
	logic               ram_re;
	page_t              ram_rdata;

	// Command decode signals.
	logic               cmd_xfer;
	logic               on_scr;
	logic               is_draw;
	logic               mem_op;
	logic [7:0]         xe_sum;
	logic [CXW-1:0]     xe_clip;
	logic [YE_W-1:0]    ye_sum;
	logic [YE_W-1:0]    ye_clip;
	logic [PG_W-1:0]    p0;
	logic [PG_W-1:0]    p1;
	logic [CNT_W-1:0]   hcount;
	logic [CNT_W-1:0]   vcount;
	page_t              bitmask;
	page_t              m0;
	page_t              m1;
	logic [ADDR_W-1:0]  start_addr;
	logic               out_free;
	logic               out_load;
	logic               fin_pix;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign out_load  = ((state_q == ST_FIN) || (state_q == ST_DONE)) && out_free;

	// Decode of the incoming command: clipping, page range, masks, start address.
	always_comb begin
		on_scr  = (cmd.x < SCREEN_WIDTH) && (cmd.y < SCREEN_HEIGHT);
		is_draw = (cmd.func == OP_SET) || (cmd.func == OP_HLINE) || (cmd.func == OP_VLINE);
		mem_op  = on_scr && (is_draw || (cmd.func == OP_GET));

		xe_sum  = {1'b0, cmd.x} + {1'b0, cmd.length};
		if (CXW'(xe_sum) > CXW'(SCREEN_WIDTH - 1)) begin
			xe_clip = CXW'(SCREEN_WIDTH - 1);
		end else begin
			xe_clip = CXW'(xe_sum);
		end
		hcount = CNT_W'(xe_clip - CXW'(cmd.x));

		ye_sum = YE_W'(cmd.y) + YE_W'(cmd.length);
		if (ye_sum > YE_W'(SCREEN_HEIGHT - 1)) begin
			ye_clip = YE_W'(SCREEN_HEIGHT - 1);
		end else begin
			ye_clip = ye_sum;
		end
		p0     = PG_W'(cmd.y >> PAGE_SHIFT);
		p1     = ye_clip[YE_W-1:PAGE_SHIFT];
		vcount = CNT_W'(p1 - p0);

		bitmask = page_t'(1) << cmd.y[PAGE_SHIFT-1:0];
		m0      = PAGE_FULL << cmd.y[PAGE_SHIFT-1:0];
		m1      = PAGE_FULL >> (LAST_BIT - ye_clip[PAGE_SHIFT-1:0]);

		start_addr = ADDR_W'(32'(p0) * SCREEN_WIDTH + 32'(cmd.x));
	end

	// Memory port selection: clearing pass, or write-back of the byte read last cycle.
	always_comb begin
		ram_re = (state_q == ST_RUN);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_valid_s1 && wr_q;
			ram_waddr = addr_s1;
			if (on_q) begin
				ram_wdata = ram_rdata | mask_s1;
			end else begin
				ram_wdata = ram_rdata & ~mask_s1;
			end
		end
	end

	assign fin_pix = get_q && ram_rdata[bit_q];

	pfde_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Sequencer: clearing pass, command capture, byte issue and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= (state_q == ST_RUN);
			// A new result loads as the old one leaves; otherwise a transfer empties it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_xfer) begin
						if (on_scr && is_draw) begin
							dirty_q <= 1'b1;
						end else if (cmd.func == OP_FLUSH) begin
							dirty_q <= 1'b0;
						end
						state_q <= mem_op ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command context, byte address walk and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					addr_q      <= start_addr;
					first_q     <= 1'b1;
					vline_q     <= (cmd.func == OP_VLINE);
					wr_q        <= (cmd.func != OP_GET);
					get_q       <= (cmd.func == OP_GET);
					on_q        <= cmd.on;
					bit_q       <= cmd.y[PAGE_SHIFT-1:0];
					res_dirty_q <= dirty_q;
					res_pix_q   <= 1'b0;
					if (cmd.func == OP_VLINE) begin
						cnt_q     <= vcount;
						m_first_q <= m0;
						m_last_q  <= m1;
						m_mid_q   <= PAGE_FULL;
					end else begin
						cnt_q     <= (cmd.func == OP_HLINE) ? hcount : '0;
						m_first_q <= bitmask;
						m_last_q  <= bitmask;
						m_mid_q   <= bitmask;
					end
				end
			end
			ST_RUN: begin
				addr_s1 <= addr_q;
				mask_s1 <= m_mid_q & (first_q ? m_first_q : PAGE_FULL)
					& ((cnt_q == '0) ? m_last_q : PAGE_FULL);
				first_q <= 1'b0;
				cnt_q   <= cnt_q - CNT_W'(1);
				addr_q  <= addr_q + (vline_q ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1));
			end
			ST_FIN: begin
				res_pix_q <= fin_pix;
				if (out_free) begin
					out_pixel_q <= fin_pix;
					out_dirty_q <= res_dirty_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_pixel_q <= res_pix_q;
					out_dirty_q <= res_dirty_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid         = out_valid_q;
	assign res.pixel         = out_pixel_q;
	assign res.update_needed = out_dirty_q;

endmodule

/* rtl/pfde_checker.sv */
// Port-level checker of the page framebuffer draw engine, with its bind.
module pfde_checker import pfde_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [FUNC_W-1:0] cmd_func,
	input logic              res_valid,
	input logic              res_ready,
	input logic              res_pixel,
	input logic              res_update_needed
);

	logic              cmd_xfer;
	logic              res_xfer;
	logic [1:0]        pend_q;
	logic [FUNC_W-1:0] f0_q;
	logic [FUNC_W-1:0] f1_q;
	logic [FUNC_W-1:0] head_func;
	logic              flushed_q;

	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign res_xfer  = res_valid && res_ready;
	assign head_func = (pend_q == 2'd2) ? f1_q : f0_q;

	// Track outstanding commands and the operation of the oldest one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			f0_q      <= OP_FLUSH;
			f1_q      <= OP_FLUSH;
			flushed_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, cmd_xfer} - {1'b0, res_xfer};
			if (cmd_xfer) begin
				f1_q <= f0_q;
				f0_q <= cmd_func;
			end
			if (res_xfer) begin
				flushed_q <= (head_func == OP_FLUSH);
			end
		end
	end

	// A stalled result holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pixel)
			&& $stable(res_update_needed))
		else $error("result changed while stalled");

	// The engine takes a command only with at most one result still owed.
	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> pend_q <= 2'd1)
		else $error("command taken with two results owed");

	// No result without a command behind it.
	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without a command");

	// Only get pixel can report a lit pixel.
	a_pix_get: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (head_func != OP_GET) |-> !res_pixel)
		else $error("pixel set on a result that is not a get");

	// The command right after a flush sees a clean screen.
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && flushed_q |-> !res_update_needed)
		else $error("dirty flag seen right after a flush");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.cmd_func          (cmd.func),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_pixel         (res.pixel),
	.res_update_needed (res.update_needed)
);
